>>> hdl/bgra_to_nv12_converter_macros.svh
// assertion macros for the bgra to nv12 converter
// no dependencies; included by files that carry concurrent checks
`ifndef BGRA_TO_NV12_CONVERTER_MACROS_SVH
`define BGRA_TO_NV12_CONVERTER_MACROS_SVH

`ifndef SYNTH

`define B2N_ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

`define B2N_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define B2N_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define B2N_ASSERT_ALWAYS(label, clk, rst, expr)
`define B2N_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define B2N_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> hdl/b2n_pkg.sv
// types, constants and arithmetic helpers for the bgra to nv12 converter
// no dependencies
`timescale 1ns / 1ps

package b2n_pkg;

  localparam int CFG_WIDTH = 13;

  typedef logic [0:0] cfg_index_t;
  typedef logic [CFG_WIDTH-1:0] cfg_data_t;

  localparam cfg_index_t REG_FRAME_WIDTH  = 1'd0;
  localparam cfg_index_t REG_FRAME_HEIGHT = 1'd1;

  localparam cfg_data_t FRAME_WIDTH_RESET  = 13'd1920;
  localparam cfg_data_t FRAME_HEIGHT_RESET = 13'd1080;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [8:0] red;
    logic [8:0] green;
    logic [8:0] blue;
  } pair_sum_t;

  localparam logic [15:0] LUMA_R      = 16'd65;
  localparam logic [15:0] LUMA_G      = 16'd129;
  localparam logic [15:0] LUMA_B      = 16'd25;
  localparam logic [7:0]  LUMA_OFFSET = 8'd16;

  localparam logic signed [16:0] CB_R = -17'sd38;
  localparam logic signed [16:0] CB_G = -17'sd74;
  localparam logic signed [16:0] CB_B = 17'sd112;
  localparam logic signed [16:0] CR_R = 17'sd112;
  localparam logic signed [16:0] CR_G = -17'sd94;
  localparam logic signed [16:0] CR_B = -17'sd18;
  localparam logic [7:0] CHROMA_OFFSET = 8'd128;

  function automatic logic [7:0] luma_of(pixel_t p);
    logic [15:0] s;
    s = 16'(p.red) * LUMA_R + 16'(p.green) * LUMA_G + 16'(p.blue) * LUMA_B;
    return LUMA_OFFSET + s[15:8];
  endfunction

  function automatic logic [7:0] average_of(logic [8:0] a, logic [8:0] b);
    logic [9:0] s;
    s = 10'(a) + 10'(b);
    return s[9:2];
  endfunction

  function automatic logic signed [16:0] chroma_sum(
    logic [7:0] r, logic [7:0] g, logic [7:0] b,
    logic signed [16:0] kr, logic signed [16:0] kg, logic signed [16:0] kb
  );
    logic signed [16:0] rs;
    logic signed [16:0] gs;
    logic signed [16:0] bs;
    rs = signed'({9'd0, r});
    gs = signed'({9'd0, g});
    bs = signed'({9'd0, b});
    return kr * rs + kg * gs + kb * bs;
  endfunction

  // divide by 256 truncating toward zero, then add the offset
  function automatic logic [7:0] chroma_of(logic signed [16:0] s);
    logic [16:0] mag;
    mag = s[16] ? 17'(-s) : 17'(s);
    return s[16] ? CHROMA_OFFSET - mag[15:8] : CHROMA_OFFSET + mag[15:8];
  endfunction

endpackage

>>> hdl/bgra_to_nv12_converter.sv
// bgra to nv12 converter top level: luma per pixel, 2x2 averaged chroma
// depends on b2n_pkg and bgra_to_nv12_converter_macros.svh
`timescale 1ns / 1ps
//
//  channel   direction  handshake              payload
//  in        sink       in_valid / in_ready    blue, green, red
//  out       source     out_valid / out_ready  luma, chroma_valid, cb, cr, frame_end
//  cfg       sink       cfg_write              cfg_index, cfg_data
//
//  one pixel per cycle while the output is not stalled; a request passes stage registers a, b and c to the result
//  the line store is a single-port-write, single-port-read ram; read on odd rows,
//  written on even rows, so a read and a write never meet on one entry
//  reset clears counters, left pixel and pipeline valids; the line store is not cleared
//  a stalled output freezes all stages and drops in_ready for that cycle

`include "bgra_to_nv12_converter_macros.svh"

module bgra_to_nv12_converter #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  b2n_pkg::cfg_index_t   cfg_index,
  input  b2n_pkg::cfg_data_t    cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            blue,
  input  logic [7:0]            green,
  input  logic [7:0]            red,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            luma,
  output logic                  chroma_valid,
  output logic [7:0]            cb,
  output logic [7:0]            cr,
  output logic                  frame_end
);

  import b2n_pkg::*;

  localparam int CW         = $clog2(MAX_WIDTH);
  localparam int RW         = $clog2(MAX_HEIGHT);
  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int DW         = CFG_WIDTH + 1;

  localparam logic [CW-1:0] COL_LAST_MAX = CW'(MAX_WIDTH - 1);
  localparam logic [RW-1:0] ROW_LAST_MAX = RW'(MAX_HEIGHT - 1);

  // configuration
  cfg_data_t frame_width;
  cfg_data_t frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped last column and row
  logic [CW-1:0] col_last;
  logic [RW-1:0] row_last;

  always_comb begin
    if (frame_width == '0) begin
      col_last = '0;
    end else if (DW'(frame_width) > DW'(MAX_WIDTH)) begin
      col_last = COL_LAST_MAX;
    end else begin
      col_last = CW'(frame_width - 1'b1);
    end
    if (frame_height == '0) begin
      row_last = '0;
    end else if (DW'(frame_height) > DW'(MAX_HEIGHT)) begin
      row_last = ROW_LAST_MAX;
    end else begin
      row_last = RW'(frame_height - 1'b1);
    end
  end

  // handshake and pipeline enable
  logic c_valid;
  logic advance;
  logic accept;

  assign advance  = !c_valid || out_ready;
  assign in_ready = advance && !rst;
  assign accept   = in_valid && in_ready;

  // position counters and left pixel
  logic [CW-1:0] column_count;
  logic [RW-1:0] row_count;
  pixel_t        left_pixel;
  pixel_t        pix;
  logic          last_col;
  logic          last_row;
  logic          odd_col;
  logic          odd_row;
  pair_sum_t     pair_now;

  assign pix      = '{red: red, green: green, blue: blue};
  assign last_col = column_count >= col_last;
  assign last_row = row_count >= row_last;
  assign odd_col  = column_count[0];
  assign odd_row  = row_count[0];

  assign pair_now.red   = 9'(left_pixel.red) + 9'(pix.red);
  assign pair_now.green = 9'(left_pixel.green) + 9'(pix.green);
  assign pair_now.blue  = 9'(left_pixel.blue) + 9'(pix.blue);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      left_pixel   <= '0;
    end else if (accept) begin
      if (!odd_col) begin
        left_pixel <= pix;
      end
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row_count + 1'b1;
      end else begin
        column_count <= column_count + 1'b1;
      end
    end
  end

  // line store of even-row pair sums
  pair_sum_t     pair_sum_line [LINE_DEPTH];
  pair_sum_t     above;
  logic [AW-1:0] line_addr;
  logic          mem_we;
  logic          mem_re;

  assign line_addr = AW'(column_count >> 1);
  assign mem_we    = accept && odd_col && !odd_row;
  assign mem_re    = accept && odd_col && odd_row;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pair_sum_line[line_addr] <= pair_now;
    end
    if (mem_re) begin
      above <= pair_sum_line[line_addr];
    end
  end

  // stage a: request registered, line store read in flight
  logic       a_valid;
  logic       a_chroma;
  logic       a_end;
  logic [7:0] a_luma;
  pair_sum_t  a_pair;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (advance) begin
      a_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_chroma <= odd_col && odd_row;
      a_end    <= last_col && last_row;
      a_luma   <= luma_of(pix);
      a_pair   <= pair_now;
    end
  end

  // stage b: 2x2 averages and signed chroma sums
  logic              b_valid;
  logic              b_chroma;
  logic              b_end;
  logic [7:0]        b_luma;
  logic signed [16:0] b_cb_sum;
  logic signed [16:0] b_cr_sum;
  logic [7:0]        avg_r;
  logic [7:0]        avg_g;
  logic [7:0]        avg_b;

  assign avg_r = average_of(a_pair.red, above.red);
  assign avg_g = average_of(a_pair.green, above.green);
  assign avg_b = average_of(a_pair.blue, above.blue);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (advance) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b_chroma <= a_chroma;
      b_end    <= a_end;
      b_luma   <= a_luma;
      b_cb_sum <= chroma_sum(avg_r, avg_g, avg_b, CB_R, CB_G, CB_B);
      b_cr_sum <= chroma_sum(avg_r, avg_g, avg_b, CR_R, CR_G, CR_B);
    end
  end

  // stage c: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (advance) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      luma         <= b_luma;
      chroma_valid <= b_chroma;
      cb           <= b_chroma ? chroma_of(b_cb_sum) : 8'd0;
      cr           <= b_chroma ? chroma_of(b_cr_sum) : 8'd0;
      frame_end    <= b_end;
    end
  end

  assign out_valid = c_valid;

  // checks
  `B2N_ASSERT_ALWAYS(a_mem_one_port, clk, rst, !(mem_we && mem_re))
  `B2N_ASSERT_NEXT(a_frame_wrap, clk, rst, accept && last_col && last_row,
    column_count == '0 && row_count == '0)
  `B2N_ASSERT_NEXT(a_chroma_tag, clk, rst, mem_re, a_valid && a_chroma)
  `B2N_ASSERT_IMPLY(a_out_chroma_odd, clk, rst, out_valid && chroma_valid && out_ready,
    !frame_end || (col_last[0] && row_last[0]))

endmodule
